[rtl/aes_like_16bit_block_cipher_unit_assert.svh]
// Assertion macros for the 16-bit cipher unit checker.
// Included by the checker file; no other dependencies.
`ifndef AES_LIKE_16BIT_BLOCK_CIPHER_UNIT_ASSERT_SVH
`define AES_LIKE_16BIT_BLOCK_CIPHER_UNIT_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define CHK_IMPLY(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("check failed");
// Next-cycle implication outside reset.
`define CHK_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("check failed");
`endif

[rtl/alc_pkg.sv]
// Package for the 16-bit cipher unit: round functions, S-boxes, constants.
// No dependencies; used by the key expansion, round and top-level modules.
package alc_pkg;
	localparam int KEY_WORDS = 8;
	localparam int ROUND_CONSTANTS = 10;
	localparam int NUM_RKEYS = KEY_WORDS + ROUND_CONSTANTS;
	localparam int NUM_STAGES = NUM_RKEYS;
	localparam int RK_IDX_W = $clog2(NUM_RKEYS);
	localparam int CFG_IDX_KEY_LOW = 0;
	localparam int CFG_IDX_KEY_HIGH = 1;
	localparam logic [15:0] RCON [ROUND_CONSTANTS] = '{
		16'h0000, 16'h0101, 16'h0202, 16'h0404, 16'h0808,
		16'h1010, 16'h2020, 16'h4040, 16'h8080, 16'h1B1B};

	typedef logic [15:0] word_t;
	typedef word_t rkey_arr_t [NUM_RKEYS];

	function automatic logic [7:0] xt8(input logic [7:0] x);
		xt8 = x[7] ? ({x[6:0], 1'b0} ^ 8'h1B) : {x[6:0], 1'b0};
	endfunction

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

	localparam logic [7:0] INV_SBOX [256] = '{
		8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
		8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
		8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
		8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
		8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
		8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
		8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
		8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
		8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
		8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
		8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
		8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
		8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
		8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
		8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};

	function automatic word_t sub_w(input word_t w);
		sub_w = {SBOX[w[15:8]], SBOX[w[7:0]]};
	endfunction

	function automatic word_t inv_sub_w(input word_t w);
		inv_sub_w = {INV_SBOX[w[15:8]], INV_SBOX[w[7:0]]};
	endfunction

	function automatic word_t shift_w(input word_t w);
		logic [15:0] v;
		v = {w[9:8], w[15:10], w[5:0], w[7:6]};
		shift_w = {v[11:0], v[15:12]};
	endfunction

	function automatic word_t inv_shift_w(input word_t w);
		logic [15:0] v;
		v = {w[3:0], w[15:4]};
		inv_shift_w = {v[13:8], v[15:14], v[1:0], v[7:2]};
	endfunction

	// Nibbles: c0 = hi(b0), c1 = hi(b1), c2 = lo(b0), c3 = lo(b1); products kept mod x^4
	function automatic word_t mix_w(input word_t w);
		logic [3:0] c [4];
		logic [3:0] d [4];
		logic [3:0] t;
		logic [7:0] x;
		c[0] = w[7:4]; c[1] = w[15:12]; c[2] = w[3:0]; c[3] = w[11:8];
		t = c[0] ^ c[1] ^ c[2] ^ c[3];
		for (int k = 0; k < 4; k++) begin
			x = xt8({4'h0, c[k] ^ c[(k + 1) % 4]});
			d[k] = c[k] ^ x[3:0] ^ t;
		end
		mix_w = {d[1], d[3], d[0], d[2]};
	endfunction

	function automatic word_t inv_mix_w(input word_t w);
		logic [7:0] c [4];
		logic [7:0] x2 [4];
		logic [7:0] x4 [4];
		logic [7:0] x8 [4];
		logic [7:0] d [4];
		c[0] = {4'h0, w[7:4]}; c[1] = {4'h0, w[15:12]};
		c[2] = {4'h0, w[3:0]}; c[3] = {4'h0, w[11:8]};
		for (int k = 0; k < 4; k++) begin
			x2[k] = xt8(c[k]);
			x4[k] = xt8(x2[k]);
			x8[k] = xt8(x4[k]);
		end
		for (int k = 0; k < 4; k++) begin
			d[k] = x8[k] ^ x4[k] ^ x2[k]
				^ x8[(k + 1) % 4] ^ x2[(k + 1) % 4] ^ c[(k + 1) % 4]
				^ x8[(k + 2) % 4] ^ x4[(k + 2) % 4] ^ c[(k + 2) % 4]
				^ x8[(k + 3) % 4] ^ c[(k + 3) % 4];
		end
		inv_mix_w = {d[1][3:0], d[3][3:0], d[0][3:0], d[2][3:0]};
	endfunction

	typedef struct packed {
		logic valid;
		logic enc;
		word_t data;
	} stage_t;
endpackage

[rtl/alc_key_expand.sv]
// Round key expansion for the 16-bit cipher unit: one mixing step per cycle.
// Depends on alc_pkg.
module alc_key_expand import alc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] key_low,
	input  logic [63:0] key_high,
	output rkey_arr_t   rkeys
);
	localparam int J_W = RK_IDX_W;
	word_t          rk_q [NUM_RKEYS];
	logic           busy_q;
	logic [J_W-1:0] i_q;
	logic [J_W-1:0] j_q;
	word_t          acc_q;
	word_t          step_val;
	logic [J_W-1:0] ic;

	assign rkeys = rk_q;
	assign step_val = mix_w(shift_w(sub_w(acc_q ^ rk_q[j_q])));
	assign ic = i_q - J_W'(KEY_WORDS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			i_q <= '0;
			j_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			i_q <= J_W'(KEY_WORDS);
			j_q <= '0;
		end else if (busy_q) begin
			if (j_q == i_q - 1'b1) begin
				j_q <= '0;
				if (i_q == J_W'(NUM_RKEYS - 1)) busy_q <= 1'b0;
				else i_q <= i_q + 1'b1;
			end else begin
				j_q <= j_q + 1'b1;
			end
		end
	end

	// Round keys hold payload only; the key words are loaded on start, the rest as derived
	always_ff @(posedge clk) begin
		if (start) begin
			for (int k = 0; k < 4; k++) begin
				rk_q[k] <= key_low[16*k +: 16];
				rk_q[k + 4] <= key_high[16*k +: 16];
			end
			acc_q <= RCON[0];
		end else if (busy_q) begin
			if (j_q == i_q - 1'b1) begin
				rk_q[i_q] <= step_val;
				if (i_q != J_W'(NUM_RKEYS - 1)) acc_q <= RCON[ic[3:0] + 4'd1];
			end else begin
				acc_q <= step_val;
			end
		end
	end
endmodule

[rtl/alc_round.sv]
// One round stage of the cipher pipeline, encrypt or decrypt per item.
// Depends on alc_pkg.
module alc_round import alc_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   adv,
	input  logic   is_last,
	input  word_t  rk_enc,
	input  word_t  rk_dec,
	input  stage_t din,
	output stage_t dout
);
	logic   valid_s1;
	logic   enc_s1;
	word_t  data_s1;
	word_t  e, d;

	always_comb begin
		e = shift_w(sub_w(din.data));
		if (!is_last) e = mix_w(e);
		e = e ^ rk_enc;
		d = inv_sub_w(inv_shift_w(din.data)) ^ rk_dec;
		if (!is_last) d = inv_mix_w(d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else if (adv) valid_s1 <= din.valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			enc_s1 <= din.enc;
			data_s1 <= din.enc ? e : d;
		end
	end

	assign dout = {valid_s1, enc_s1, data_s1};
endmodule

[rtl/aes_like_16bit_block_cipher_unit.sv]
// Top level of the 16-bit AES-like cipher unit: key expansion and round pipeline.
// Depends on alc_pkg, alc_key_expand, alc_round.
//
// Usage: write key_words_low (index 0) and key_words_high (index 1) through
// cfg_we/cfg_idx/cfg_data. Each write starts a key expansion of one step per
// earlier key for each derived key (8 + 9 + ... + 17 = 125 steps); the keys
// are ready when it ends; send requests only after that.
// Input channel: in_valid/in_stall with action (1 encrypt, 0 decrypt) and
// data_in. Output channel: out_valid/out_stall with data_out.
// The datapath is a pipeline of one key-add stage plus 17 round stages, one
// register each; a new request can enter every cycle while in_stall is low.
// The whole pipeline holds while out_stall is high and the last stage holds a
// result; in_stall is raised only while the last stage holds a result that
// cannot move.
// Reset clears all valid bits and the expansion control; round keys are
// undefined until the first key write.
module aes_like_16bit_block_cipher_unit import alc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_idx,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        action,
	input  logic [15:0] data_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] data_out
);
	logic [63:0] key_low_q, key_high_q;
	logic        start_q;
	rkey_arr_t   rkeys;
	stage_t      st [1:NUM_STAGES];
	logic        first_valid_s1;
	logic        first_enc_s1;
	word_t       first_data_s1;
	logic        adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q <= '0;
			key_high_q <= '0;
			start_q <= 1'b0;
		end else begin
			start_q <= cfg_we;
			if (cfg_we && cfg_idx == 1'(CFG_IDX_KEY_LOW)) key_low_q <= cfg_data;
			if (cfg_we && cfg_idx == 1'(CFG_IDX_KEY_HIGH)) key_high_q <= cfg_data;
		end
	end

	alc_key_expand u_kexp (
		.clk(clk), .arst_n(arst_n), .start(start_q),
		.key_low(key_low_q), .key_high(key_high_q), .rkeys(rkeys)
	);

	// Advance everything unless the last stage holds a result that is stalled
	assign adv = !(st[NUM_STAGES].valid && out_stall);
	assign in_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) first_valid_s1 <= 1'b0;
		else if (adv) first_valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			first_enc_s1 <= action;
			first_data_s1 <= data_in ^ (action ? rkeys[0] : rkeys[NUM_RKEYS - 1]);
		end
	end

	assign st[1] = {first_valid_s1, first_enc_s1, first_data_s1};

	for (genvar r = 1; r < NUM_STAGES; r++) begin : g_round
		alc_round u_round (
			.clk(clk), .arst_n(arst_n), .adv(adv),
			.is_last(1'(r == NUM_STAGES - 1)),
			.rk_enc(rkeys[r]), .rk_dec(rkeys[NUM_RKEYS - 1 - r]),
			.din(st[r]), .dout(st[r + 1])
		);
	end

	assign out_valid = st[NUM_STAGES].valid;
	assign data_out = st[NUM_STAGES].data;
endmodule

[rtl/alc_checker.sv]
// Port-level checker for the 16-bit cipher unit, bound to the top level.
// Depends on aes_like_16bit_block_cipher_unit_assert.svh.
`include "aes_like_16bit_block_cipher_unit_assert.svh"
module alc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [15:0] data_out
);
	`CHK_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(data_out))
	`CHK_IMPLY(a_stall_cause, clk, arst_n, in_stall, out_valid && out_stall)
	`CHK_IMPLY(a_free_flow, clk, arst_n, !out_valid, !in_stall)
endmodule

bind aes_like_16bit_block_cipher_unit alc_checker u_alc_checker (
	.clk(clk), .arst_n(arst_n), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .data_out(data_out)
);
